[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the draw engine RTL
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check
`define MFDE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check
`define MFDE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/mfde_pkg.sv]
// ----------------------------------------------------------------------------
// mfde_pkg
// Types, codes and defaults shared by the framebuffer draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 64;

   typedef enum logic [4:0] {
      OP_SET_PIXEL    = 5'd0,
      OP_CLEAR_PIXEL  = 5'd1,
      OP_INVERT_PIXEL = 5'd2,
      OP_GET_PIXEL    = 5'd3,
      OP_LINE         = 5'd4,
      OP_CLEAR_LINE   = 5'd5,
      OP_DASHED_LINE  = 5'd6,
      OP_RECT         = 5'd7,
      OP_FILL_RECT    = 5'd8,
      OP_CLEAR_RECT   = 5'd9,
      OP_INVERT_AREA  = 5'd10,
      OP_CIRCLE       = 5'd11,
      OP_FILL_CIRCLE  = 5'd12,
      OP_CLEAR_CIRCLE = 5'd13,
      OP_CLEAR_AREA   = 5'd14,
      OP_SHIFT_UP     = 5'd15,
      OP_READ_BYTE    = 5'd16
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_SET    = 2'd0,
      MODE_CLEAR  = 2'd1,
      MODE_INVERT = 2'd2
   } mode_type;

   localparam logic [1:0] AREA_BANNER = 2'd0;
   localparam logic [1:0] AREA_MAIN   = 2'd1;
   localparam logic [1:0] AREA_ALL    = 2'd2;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  x_a;
      logic [7:0]  y_a;
      logic [7:0]  x_b;
      logic [7:0]  y_b;
      logic [6:0]  radius;
   } cmd_type;

   typedef struct packed {
      logic        valid;
      mode_type    mode;
      logic [7:0]  x;
      logic [7:0]  y;
   } pix_type;

   typedef enum logic [2:0] {
      W_IDLE, W_POINT, W_LSETUP, W_LINE, W_RECT, W_FILL, W_CUPD, W_CPTS
   } walk_state_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WALK, ST_RMW, ST_AREA, ST_SH_SRC1, ST_SH_SRC2,
      ST_SH_DST, ST_SH_WRITE, ST_FETCH, ST_CAPTURE, ST_DONE
   } ctl_state_type;

   function automatic mode_type mode_of(input opcode_type op);
      mode_type m;
      m = MODE_SET;
      unique case (op)
         OP_CLEAR_PIXEL, OP_CLEAR_LINE, OP_CLEAR_RECT, OP_CLEAR_CIRCLE: m = MODE_CLEAR;
         OP_INVERT_PIXEL, OP_INVERT_AREA:                               m = MODE_INVERT;
         default:                                                       m = MODE_SET;
      endcase
      return m;
   endfunction

endpackage

[rtl/core/mfde_ram.sv]
// ----------------------------------------------------------------------------
// mfde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mfde_walk.sv]
// ----------------------------------------------------------------------------
// mfde_walk
// Shape walker: turns a pixel, line, rectangle or circle request into a
// stream of pixel writes, one per handshake with the store controller.
// ----------------------------------------------------------------------------
module mfde_walk import mfde_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  cmd_type cmd,
   input  logic    pix_ready,
   output pix_type pix,
   output logic    busy
);

   walk_state_type state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   mode_type              mode_ff, mode_in;
   logic [7:0]            lax_ff, lax_in, lay_ff, lay_in, lbx_ff, lbx_in;
   logic [7:0]            dx_ff, dx_in, dy_ff, dy_in;
   logic signed [9:0]     err_ff, err_in;
   logic                  yneg_ff, yneg_in, steep_ff, steep_in;
   logic [7:0]            i_ff, i_in, j_ff, j_in;
   logic [1:0]            ph_ff, ph_in;
   logic [7:0]            cx_ff, cx_in;
   logic signed [11:0]    f_ff, f_in, ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic                  first_ff, first_in;
   logic [2:0]            k_ff, k_in;

   // line setup terms
   logic [7:0]         adx, ady, p_ax, p_ay, p_bx, p_by, s_ax, s_ay, s_bx, s_by;
   logic               steep;
   logic signed [9:0]  err_step;
   // rectangle and circle terms
   logic [7:0]         lim, half, col, span_last;
   logic               filled, last_k, fpos;
   logic signed [11:0] ddy_n, f1, ddx_n;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      mode_in  = mode_ff;
      lax_in   = lax_ff;
      lay_in   = lay_ff;
      lbx_in   = lbx_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      err_in   = err_ff;
      yneg_in  = yneg_ff;
      steep_in = steep_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      ph_in    = ph_ff;
      cx_in    = cx_ff;
      f_in     = f_ff;
      ddx_in   = ddx_ff;
      ddy_in   = ddy_ff;
      first_in = first_ff;
      k_in     = k_ff;
      pix       = '0;
      pix.mode  = mode_ff;

      // line setup: order the end points along the major axis
      adx   = (cmd_ff.x_b >= cmd_ff.x_a) ? cmd_ff.x_b - cmd_ff.x_a : cmd_ff.x_a - cmd_ff.x_b;
      ady   = (cmd_ff.y_b >= cmd_ff.y_a) ? cmd_ff.y_b - cmd_ff.y_a : cmd_ff.y_a - cmd_ff.y_b;
      steep = ady > adx;
      p_ax  = steep ? cmd_ff.y_a : cmd_ff.x_a;
      p_ay  = steep ? cmd_ff.x_a : cmd_ff.y_a;
      p_bx  = steep ? cmd_ff.y_b : cmd_ff.x_b;
      p_by  = steep ? cmd_ff.x_b : cmd_ff.y_b;
      s_ax  = (p_ax > p_bx) ? p_bx : p_ax;
      s_ay  = (p_ax > p_bx) ? p_by : p_ay;
      s_bx  = (p_ax > p_bx) ? p_ax : p_bx;
      s_by  = (p_ax > p_bx) ? p_ay : p_by;
      err_step = err_ff - $signed({2'b00, dy_ff});

      // rectangle and circle selection
      lim      = ph_ff[1] ? cmd_ff.y_b : cmd_ff.x_b;
      filled   = cmd_ff.opcode != OP_CIRCLE;
      half     = k_ff[1] ? i_ff : cx_ff;
      col      = cmd_ff.x_a;
      unique case (k_ff[1:0])
         2'd0: begin col = cmd_ff.x_a + i_ff; half = cx_ff; end
         2'd1: begin col = cmd_ff.x_a - i_ff; half = cx_ff; end
         2'd2: begin col = cmd_ff.x_a + cx_ff; half = i_ff; end
         2'd3: begin col = cmd_ff.x_a - cx_ff; half = i_ff; end
         default: begin col = cmd_ff.x_a; half = i_ff; end
      endcase
      span_last = {half[6:0], 1'b0};
      last_k    = filled ? (first_ff ? (k_ff == 3'd0) : (k_ff == 3'd3)) : (k_ff == 3'd7);
      fpos      = !f_ff[11];
      ddy_n     = fpos ? ddy_ff + 12'sd2 : ddy_ff;
      f1        = fpos ? f_ff + ddy_n : f_ff;
      ddx_n     = ddx_ff + 12'sd2;

      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               cmd_in   = cmd;
               mode_in  = mode_of(cmd.opcode);
               i_in     = '0;
               j_in     = '0;
               ph_in    = '0;
               k_in     = '0;
               first_in = 1'b1;
               // circle offsets: i is x, cx is y
               i_in     = '0;
               cx_in    = {1'b0, cmd.radius};
               f_in     = 12'sd1 - $signed({5'b0, cmd.radius});
               ddx_in   = 12'sd1;
               ddy_in   = -$signed({4'b0, cmd.radius, 1'b0});
               unique case (cmd.opcode)
                  OP_SET_PIXEL, OP_CLEAR_PIXEL, OP_INVERT_PIXEL: state_in = W_POINT;
                  OP_LINE, OP_CLEAR_LINE, OP_DASHED_LINE:        state_in = W_LSETUP;
                  OP_RECT:                                       state_in = W_RECT;
                  OP_FILL_RECT, OP_CLEAR_RECT, OP_INVERT_AREA: begin
                     state_in = (cmd.x_b == '0 || cmd.y_b == '0) ? W_IDLE : W_FILL;
                  end
                  OP_CIRCLE, OP_FILL_CIRCLE, OP_CLEAR_CIRCLE:    state_in = W_CPTS;
                  default:                                       state_in = W_IDLE;
               endcase
            end
         end
         W_POINT: begin
            pix.valid = 1'b1;
            pix.x     = cmd_ff.x_a;
            pix.y     = cmd_ff.y_a;
            if (pix_ready) begin
               state_in = W_IDLE;
            end
         end
         W_LSETUP: begin
            steep_in = steep;
            lax_in   = s_ax;
            lay_in   = s_ay;
            lbx_in   = s_bx;
            dx_in    = s_bx - s_ax;
            dy_in    = (s_by >= s_ay) ? s_by - s_ay : s_ay - s_by;
            err_in   = $signed({3'b000, dx_in[7:1]});
            yneg_in  = !(s_ay < s_by);
            state_in = W_LINE;
         end
         W_LINE: begin
            // step along the major axis; end point excluded
            if (lax_ff < lbx_ff) begin
               pix.valid = (cmd_ff.opcode != OP_DASHED_LINE) || !lax_ff[0];
               pix.x     = steep_ff ? lay_ff : lax_ff;
               pix.y     = steep_ff ? lax_ff : lay_ff;
               if (!pix.valid || pix_ready) begin
                  lax_in = lax_ff + 8'd1;
                  err_in = err_step;
                  if (err_step < 0) begin
                     lay_in = yneg_ff ? lay_ff - 8'd1 : lay_ff + 8'd1;
                     err_in = err_step + $signed({2'b00, dx_ff});
                  end
               end
            end else begin
               state_in = W_IDLE;
            end
         end
         W_RECT: begin
            // top row, bottom row, left column, right column
            if (i_ff < lim) begin
               pix.valid = 1'b1;
               unique case (ph_ff)
                  2'd0: begin pix.x = cmd_ff.x_a + i_ff; pix.y = cmd_ff.y_a; end
                  2'd1: begin
                     pix.x = cmd_ff.x_a + i_ff;
                     pix.y = cmd_ff.y_a + cmd_ff.y_b - 8'd1;
                  end
                  2'd2: begin pix.x = cmd_ff.x_a; pix.y = cmd_ff.y_a + i_ff; end
                  2'd3: begin
                     pix.x = cmd_ff.x_a + cmd_ff.x_b - 8'd1;
                     pix.y = cmd_ff.y_a + i_ff;
                  end
                  default: begin pix.x = cmd_ff.x_a; pix.y = cmd_ff.y_a; end
               endcase
               if (pix_ready) begin
                  i_in = i_ff + 8'd1;
               end
            end else begin
               i_in  = '0;
               ph_in = ph_ff + 2'd1;
               if (ph_ff == 2'd3) begin
                  state_in = W_IDLE;
               end
            end
         end
         W_FILL: begin
            pix.valid = 1'b1;
            pix.x     = cmd_ff.x_a + i_ff;
            pix.y     = cmd_ff.y_a + j_ff;
            if (pix_ready) begin
               if (j_ff == cmd_ff.y_b - 8'd1) begin
                  j_in = '0;
                  i_in = i_ff + 8'd1;
                  if (i_ff == cmd_ff.x_b - 8'd1) begin
                     state_in = W_IDLE;
                  end
               end else begin
                  j_in = j_ff + 8'd1;
               end
            end
         end
         W_CUPD: begin
            // midpoint step
            cx_in    = fpos ? cx_ff - 8'd1 : cx_ff;
            ddy_in   = ddy_n;
            i_in     = i_ff + 8'd1;
            ddx_in   = ddx_n;
            f_in     = f1 + ddx_n;
            k_in     = '0;
            j_in     = '0;
            state_in = W_CPTS;
         end
         W_CPTS: begin
            pix.valid = 1'b1;
            if (filled) begin
               pix.x = col;
               pix.y = cmd_ff.y_a - half + j_ff;
            end else begin
               unique case (k_ff)
                  3'd0: begin pix.x = cmd_ff.x_a + i_ff;  pix.y = cmd_ff.y_a + cx_ff; end
                  3'd1: begin pix.x = cmd_ff.x_a - i_ff;  pix.y = cmd_ff.y_a + cx_ff; end
                  3'd2: begin pix.x = cmd_ff.x_a + i_ff;  pix.y = cmd_ff.y_a - cx_ff; end
                  3'd3: begin pix.x = cmd_ff.x_a - i_ff;  pix.y = cmd_ff.y_a - cx_ff; end
                  3'd4: begin pix.x = cmd_ff.x_a + cx_ff; pix.y = cmd_ff.y_a + i_ff;  end
                  3'd5: begin pix.x = cmd_ff.x_a - cx_ff; pix.y = cmd_ff.y_a + i_ff;  end
                  3'd6: begin pix.x = cmd_ff.x_a + cx_ff; pix.y = cmd_ff.y_a - i_ff;  end
                  3'd7: begin pix.x = cmd_ff.x_a - cx_ff; pix.y = cmd_ff.y_a - i_ff;  end
                  default: begin pix.x = cmd_ff.x_a; pix.y = cmd_ff.y_a; end
               endcase
            end
            if (pix_ready) begin
               if (filled && j_ff != span_last) begin
                  j_in = j_ff + 8'd1;
               end else begin
                  j_in = '0;
                  if (last_k) begin
                     first_in = 1'b0;
                     k_in     = '0;
                     state_in = (i_ff < cx_ff) ? W_CUPD : W_IDLE;
                  end else begin
                     k_in = k_ff + 3'd1;
                  end
               end
            end
         end
         default: state_in = W_IDLE;
      endcase
   end

   // hold walker state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff   <= cmd_in;
      mode_ff  <= mode_in;
      lax_ff   <= lax_in;
      lay_ff   <= lay_in;
      lbx_ff   <= lbx_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      err_ff   <= err_in;
      yneg_ff  <= yneg_in;
      steep_ff <= steep_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      ph_ff    <= ph_in;
      cx_ff    <= cx_in;
      f_ff     <= f_in;
      ddx_ff   <= ddx_in;
      ddy_ff   <= ddy_in;
      first_ff <= first_in;
      k_ff     <= k_in;
   end

   assign busy  = state_ff != W_IDLE;

endmodule

[rtl/core/mono_framebuffer_draw_engine.sv]
// Get pixel and read byte: read in ST_FETCH, byte captured in ST_CAPTURE.
// Shapes: an on-screen pixel is read in ST_WALK and written back in ST_RMW,
// a read-modify-write of the store; off-screen or skipped steps pass ST_WALK only.
// Clear area writes one byte per cycle; shift up: three reads, one write per byte.
// One request is worked at a time; the next is taken while a response waits.
// Reset: a clearing pass zeroes all STORE_BYTES bytes (1024 at 128x64).
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Page-organized monochrome framebuffer with pixel, line, rectangle and
// circle drawing, area clear, shift up and byte readback.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mono_framebuffer_draw_engine import mfde_pkg::*; #(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] req_opcode,
   input  logic [7:0] req_x_a,
   input  logic [7:0] req_y_a,
   input  logic [7:0] req_x_b,
   input  logic [7:0] req_y_b,
   input  logic [6:0] req_radius,
   input  logic [1:0] req_area_select,
   input  logic [7:0] req_shift_rows,
   input  logic [9:0] req_byte_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_pixel_value,
   output logic [7:0] rsp_byte_value
);

   localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
   localparam logic [ADDR_W-1:0] MAIN_ADDR = ADDR_W'(SCREEN_WIDTH);
   localparam logic [ADDR_W-1:0] BANNER_LAST = ADDR_W'(SCREEN_WIDTH - 1);

   ctl_state_type     state_ff, state_in;
   opcode_type        op_ff, op_in;
   logic [7:0]        x_ff, x_in, y_ff, y_in, rows_ff, rows_in;
   logic [9:0]        bidx_ff, bidx_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, last_ff, last_in;
   logic [7:0]        mask_ff, mask_in;
   mode_type          mode_ff, mode_in;
   logic [PAGE_W-1:0] sp_ff, sp_in;
   logic [7:0]        sx_ff, sx_in, src1_ff, src1_in, src2_ff, src2_in;
   logic              res_pix_ff, res_pix_in;
   logic [7:0]        res_byte_ff, res_byte_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_pix_ff, rsp_pix_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_wdata, ram_rdata;
   logic              walk_start, walk_busy, pix_ready;
   cmd_type           walk_cmd;
   pix_type           pix;

   logic              pix_on;
   logic              src1_ok, src2_ok;
   logic [15:0]       src_pair;
   logic [7:0]        shifted;
   logic              accept;

   function automatic logic [ADDR_W-1:0] byte_addr(input int page, input int col);
      return ADDR_W'(page * SCREEN_WIDTH + col);
   endfunction

   mfde_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign walk_cmd.opcode = opcode_type'(req_opcode);
   assign walk_cmd.x_a    = req_x_a;
   assign walk_cmd.y_a    = req_y_a;
   assign walk_cmd.x_b    = req_x_b;
   assign walk_cmd.y_b    = req_y_b;
   assign walk_cmd.radius = req_radius;

   mfde_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (walk_start),
      .cmd       (walk_cmd),
      .pix_ready (pix_ready),
      .pix       (pix),
      .busy      (walk_busy)
   );

   assign accept = req_valid && req_ready;
   assign pix_on = (int'(pix.x) < SCREEN_WIDTH) && (int'(pix.y) < SCREEN_HEIGHT);

   // shift source pages and the realigned byte
   assign src1_ok  = int'(sp_ff) + int'(rows_ff[7:3]) < PAGE_COUNT;
   assign src2_ok  = int'(sp_ff) + int'(rows_ff[7:3]) + 1 < PAGE_COUNT;
   assign src_pair = {src2_ff, src1_ff} >> rows_ff[2:0];
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         if (int'(sp_ff) * 8 + b >= SCREEN_HEIGHT) begin
            shifted[b] = ram_rdata[b];
         end else if (int'(sp_ff) * 8 + b + int'(rows_ff) < SCREEN_HEIGHT) begin
            shifted[b] = src_pair[b];
         end else begin
            shifted[b] = 1'b0;
         end
      end
   end

   // control: request decode, store sequencing, response hand-off
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      rows_in     = rows_ff;
      bidx_in     = bidx_ff;
      addr_in     = addr_ff;
      last_in     = last_ff;
      mask_in     = mask_ff;
      mode_in     = mode_ff;
      sp_in       = sp_ff;
      sx_in       = sx_ff;
      src1_in     = src1_ff;
      src2_in     = src2_ff;
      res_pix_in  = res_pix_ff;
      res_byte_in = res_byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pix_in  = rsp_pix_ff;
      rsp_byte_in = rsp_byte_ff;
      req_ready   = 1'b0;
      walk_start  = 1'b0;
      pix_ready   = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = addr_ff;
      ram_wdata   = '0;
      ram_raddr   = addr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we  = 1'b1;
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               op_in       = opcode_type'(req_opcode);
               x_in        = req_x_a;
               y_in        = req_y_a;
               rows_in     = req_shift_rows;
               bidx_in     = req_byte_index;
               res_pix_in  = 1'b0;
               res_byte_in = '0;
               sp_in       = '0;
               sx_in       = '0;
               state_in    = ST_DONE;
               unique case (opcode_type'(req_opcode))
                  OP_GET_PIXEL, OP_READ_BYTE: state_in = ST_FETCH;
                  OP_CLEAR_AREA: begin
                     if (req_area_select == AREA_BANNER) begin
                        addr_in  = '0;
                        last_in  = BANNER_LAST;
                        state_in = ST_AREA;
                     end else if (req_area_select == AREA_ALL) begin
                        addr_in  = '0;
                        last_in  = LAST_ADDR;
                        state_in = ST_AREA;
                     end else if (req_area_select == AREA_MAIN && PAGE_COUNT > 1) begin
                        addr_in  = MAIN_ADDR;
                        last_in  = LAST_ADDR;
                        state_in = ST_AREA;
                     end
                  end
                  OP_SHIFT_UP: begin
                     if (int'(req_shift_rows) >= SCREEN_HEIGHT) begin
                        if (PAGE_COUNT > 1) begin
                           addr_in  = MAIN_ADDR;
                           last_in  = LAST_ADDR;
                           state_in = ST_AREA;
                        end
                     end else if (req_shift_rows != '0) begin
                        state_in = ST_SH_SRC1;
                     end
                  end
                  OP_SET_PIXEL, OP_CLEAR_PIXEL, OP_INVERT_PIXEL, OP_LINE,
                  OP_CLEAR_LINE, OP_DASHED_LINE, OP_RECT, OP_FILL_RECT,
                  OP_CLEAR_RECT, OP_INVERT_AREA, OP_CIRCLE, OP_FILL_CIRCLE,
                  OP_CLEAR_CIRCLE: begin
                     walk_start = 1'b1;
                     state_in   = ST_WALK;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            // take one pixel; read its byte when it lands on screen
            if (pix.valid) begin
               pix_ready = 1'b1;
               if (pix_on) begin
                  ram_raddr = byte_addr(int'(pix.y[7:3]), int'(pix.x));
                  addr_in   = ram_raddr;
                  mask_in   = 8'd1 << pix.y[2:0];
                  mode_in   = pix.mode;
                  state_in  = ST_RMW;
               end
            end else if (!walk_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_RMW: begin
            ram_we = 1'b1;
            unique case (mode_ff)
               MODE_SET:    ram_wdata = ram_rdata | mask_ff;
               MODE_CLEAR:  ram_wdata = ram_rdata & ~mask_ff;
               MODE_INVERT: ram_wdata = ram_rdata ^ mask_ff;
               default:     ram_wdata = ram_rdata;
            endcase
            state_in = ST_WALK;
         end
         ST_AREA: begin
            ram_we  = 1'b1;
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_SH_SRC1: begin
            ram_raddr = byte_addr(int'(sp_ff) + int'(rows_ff[7:3]), int'(sx_ff));
            state_in  = ST_SH_SRC2;
         end
         ST_SH_SRC2: begin
            src1_in   = src1_ok ? ram_rdata : 8'd0;
            ram_raddr = byte_addr(int'(sp_ff) + int'(rows_ff[7:3]) + 1, int'(sx_ff));
            state_in  = ST_SH_DST;
         end
         ST_SH_DST: begin
            src2_in   = src2_ok ? ram_rdata : 8'd0;
            ram_raddr = byte_addr(int'(sp_ff), int'(sx_ff));
            addr_in   = ram_raddr;
            state_in  = ST_SH_WRITE;
         end
         ST_SH_WRITE: begin
            ram_we    = 1'b1;
            ram_wdata = shifted;
            state_in  = ST_SH_SRC1;
            if (int'(sx_ff) == SCREEN_WIDTH - 1) begin
               sx_in = '0;
               sp_in = sp_ff + PAGE_W'(1);
               if (int'(sp_ff) == PAGE_COUNT - 1) begin
                  state_in = ST_DONE;
               end
            end else begin
               sx_in = sx_ff + 8'd1;
            end
         end
         ST_FETCH: begin
            state_in = ST_DONE;
            if (op_ff == OP_GET_PIXEL) begin
               if (int'(x_ff) < SCREEN_WIDTH && int'(y_ff) < SCREEN_HEIGHT) begin
                  ram_raddr = byte_addr(int'(y_ff[7:3]), int'(x_ff));
                  state_in  = ST_CAPTURE;
               end
            end else if (int'(bidx_ff) < STORE_BYTES) begin
               ram_raddr = ADDR_W'(bidx_ff);
               state_in  = ST_CAPTURE;
            end
         end
         ST_CAPTURE: begin
            if (op_ff == OP_GET_PIXEL) begin
               res_pix_in = ram_rdata[y_ff[2:0]];
            end else begin
               res_byte_in = ram_rdata;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand off once the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = res_pix_ff;
               rsp_byte_in  = res_byte_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      rows_ff     <= rows_in;
      bidx_ff     <= bidx_in;
      last_ff     <= last_in;
      mask_ff     <= mask_in;
      mode_ff     <= mode_in;
      sp_ff       <= sp_in;
      sx_ff       <= sx_in;
      src1_ff     <= src1_in;
      src2_ff     <= src2_in;
      res_pix_ff  <= res_pix_in;
      res_byte_ff <= res_byte_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pix_ff;
   assign rsp_byte_value  = rsp_byte_ff;

   `MFDE_ASSERT_NOW(a_write_states, ram_we, (state_ff == ST_CLEAR || state_ff == ST_RMW || state_ff == ST_AREA || state_ff == ST_SH_WRITE), "store written outside a write state")
   `MFDE_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff != ST_IDLE, "request accepted but control stayed idle")
   `MFDE_ASSERT_NOW(a_walk_owned, walk_busy, (state_ff == ST_WALK || state_ff == ST_RMW), "walker busy while control not walking")
   `MFDE_ASSERT_NOW(a_rmw_after_read, state_ff == ST_RMW, $past(state_ff) == ST_WALK, "write-back without a preceding read")

endmodule
